// ===== design/lbrle_pkg.sv =====
// ----------------------------------------------------------------------------
// lbrle_pkg: shared types and constants
// word layouts, register indexes and helpers for the block run-length encoder
// ----------------------------------------------------------------------------
`default_nettype none

package lbrle_pkg;

  localparam int DEF_MAX_BLOCK_SIDE = 64;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int SIDE_W     = 7;
  localparam int DIFF_W     = 10;
  localparam int LEN_W      = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIDE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIFF   = 1'b1;

  localparam logic [SIDE_W-1:0] BLOCK_SIDE_RST = 7'd8;
  localparam logic [LEN_W-1:0]  LEN_MAX        = 13'h1fff;

  typedef struct packed {
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
    logic       end_of_image;
  } pix_t;

  typedef struct packed {
    logic [7:0]       run_blue;
    logic [7:0]       run_green;
    logic [7:0]       run_red;
    logic [LEN_W-1:0] run_count;
    logic             final_run;
  } run_t;

  // results of one pixel, first result in r0
  typedef struct packed {
    logic [1:0] n;
    run_t       r0;
    run_t       r1;
  } push_t;

  // last position index of a block: side clamped to 1..max_side, squared, minus one
  function automatic int area_m1(input int side, input int max_side);
    int s;
    s = side;
    if (s < 1) s = 1;
    if (s > max_side) s = max_side;
    return s * s - 1;
  endfunction

  function automatic logic [DIFF_W-1:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {{(DIFF_W-8){1'b0}}, d};
  endfunction

endpackage

`default_nettype wire

// ===== design/lbrle_core.sv =====
// ----------------------------------------------------------------------------
// lbrle_core: input register and run update
// holds the open run, block position and config, emits up to two runs per pixel
// ----------------------------------------------------------------------------
`default_nettype none

module lbrle_core
  import lbrle_pkg::*;
#(
  parameter int MAX_BLOCK_SIDE = DEF_MAX_BLOCK_SIDE
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pix_t                  in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  room,
  output push_t                      push
);

  localparam int AREA = MAX_BLOCK_SIDE * MAX_BLOCK_SIDE;
  localparam int PW   = (AREA > 1) ? $clog2(AREA) : 1;

  logic [PW-1:0]     area_m1_r;
  logic [DIFF_W-1:0] max_diff_r;

  logic              s1_valid_r, s1_valid_nxt;
  pix_t              s1_data_r;

  logic [7:0]        held_b_r, held_b_nxt;
  logic [7:0]        held_g_r, held_g_nxt;
  logic [7:0]        held_r_r, held_r_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic              open_r, open_nxt;

  logic              go, accept, last, similar;
  logic [DIFF_W-1:0] diff;
  run_t              held_run, close_run;

  assign go       = s1_valid_r && room;
  assign in_stall = s1_valid_r && !room;
  assign accept   = in_valid && !in_stall;

  assign s1_valid_nxt = accept ? 1'b1 : (go ? 1'b0 : s1_valid_r);

  assign last    = (pos_r >= area_m1_r);
  assign diff    = abs_diff(held_b_r, s1_data_r.pixel_blue)
                 + abs_diff(held_g_r, s1_data_r.pixel_green)
                 + abs_diff(held_r_r, s1_data_r.pixel_red);
  assign similar = (diff <= max_diff_r);

  assign held_run = '{run_blue: held_b_r, run_green: held_g_r, run_red: held_r_r,
                      run_count: len_r, final_run: 1'b0};

  always_comb begin
    held_b_nxt = held_b_r;
    held_g_nxt = held_g_r;
    held_r_nxt = held_r_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    open_nxt   = open_r;
    push       = '0;
    close_run  = '0;
    if (go) begin
      if (!open_r || last || !similar) begin
        // current run closes (if any), pixel opens a new run
        if (open_r) begin
          push.r0 = held_run;
          push.n  = 2'd1;
        end
        held_b_nxt = s1_data_r.pixel_blue;
        held_g_nxt = s1_data_r.pixel_green;
        held_r_nxt = s1_data_r.pixel_red;
        len_nxt    = {{(LEN_W-1){1'b0}}, 1'b1};
        open_nxt   = 1'b1;
      end else if (len_r != LEN_MAX) begin
        len_nxt = len_r + 1'b1;
      end
      pos_nxt = last ? '0 : pos_r + 1'b1;
      if (s1_data_r.end_of_image) begin
        close_run = '{run_blue: held_b_nxt, run_green: held_g_nxt, run_red: held_r_nxt,
                      run_count: len_nxt, final_run: 1'b1};
        if (push.n == 2'd0) begin
          push.r0 = close_run;
        end else begin
          push.r1 = close_run;
        end
        push.n   = push.n + 2'd1;
        open_nxt = 1'b0;
        len_nxt  = '0;
        pos_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      held_b_r   <= '0;
      held_g_r   <= '0;
      held_r_r   <= '0;
      len_r      <= '0;
      pos_r      <= '0;
      open_r     <= 1'b0;
      area_m1_r  <= PW'(area_m1(int'(BLOCK_SIDE_RST), MAX_BLOCK_SIDE));
      max_diff_r <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      held_b_r   <= held_b_nxt;
      held_g_r   <= held_g_nxt;
      held_r_r   <= held_r_nxt;
      len_r      <= len_nxt;
      pos_r      <= pos_nxt;
      open_r     <= open_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_SIDE: area_m1_r  <= PW'(area_m1(int'(cfg_data[SIDE_W-1:0]), MAX_BLOCK_SIDE));
          CFG_MAX_DIFF:   max_diff_r <= cfg_data[DIFF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/lbrle_ofifo.sv =====
// ----------------------------------------------------------------------------
// lbrle_ofifo: result queue
// four-entry queue, takes up to two runs a cycle and, unless out_stall holds it, hands out one
// ----------------------------------------------------------------------------
`default_nettype none

module lbrle_ofifo
  import lbrle_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_stall,
  output run_t       out_data
);

  run_t       mem [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count_r != 3'd0);
  assign out_data  = mem[rd_ptr_r];
  // space for two runs, judged on the registered fill
  assign room      = (count_r <= 3'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push.n;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      count_r  <= count_r + {1'b0, push.n} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_r + 2'd1] <= push.r1;
    end
  end

endmodule

`default_nettype wire

// ===== design/lossy_block_run_length_encoder.sv =====
// ----------------------------------------------------------------------------
// lossy_block_run_length_encoder: top level
// lossy run-length coding of bgr pixels streamed in block-scan order
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            word
//  in_      input      in_valid / in_stall  pix_t: pixel bgr, end_of_image
//  out_     output     out_valid/out_stall  run_t: run bgr, run_count, final_run
//  cfg_     input      cfg_we               cfg_index, cfg_data (no read-back)
//
//  one pixel word per cycle sustained while the queue has room; a pixel passes
//  the input register, then the result queue, before its first run word at out_
//  a pixel can make two run words, the queue drains them one per cycle while
//  out_stall is low, and in_stall rises when it cannot take two more
//  synchronous active-low reset: no open run, position zero, block side 8,
//  max_diff 0, queue empty
//
`default_nettype none

module lossy_block_run_length_encoder
  import lbrle_pkg::*;
#(
  parameter int MAX_BLOCK_SIDE = DEF_MAX_BLOCK_SIDE
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pix_t                  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output run_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // results of the pixel in the core register, queued next edge
  push_t push;
  // queue can take two more runs
  logic  room;

  lbrle_core #(
    .MAX_BLOCK_SIDE(MAX_BLOCK_SIDE)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .room     (room),
    .push     (push)
  );

  // output side: holds finished runs so the input keeps moving
  lbrle_ofifo u_ofifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for lossy_block_run_length_encoder
// streams pixel words through random sender gaps and receiver stalls, keeps a
// run predictor in step with every accepted pixel and compares each run word
// field by field, in order, against the runs it predicted
// ----------------------------------------------------------------------------

module tb;
  import lbrle_pkg::*;

  localparam int MAX_SIDE     = DEF_MAX_BLOCK_SIDE;
  localparam int STALL_MAX    = 19;
  localparam int QUIET_MAX    = 5000;   // cycles with no word moving on either side
  localparam int SHOWN_MAX    = 10;
  localparam int LONG_RUN     = 150;
  localparam int RANDOM_ITEMS = 460;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  pix_t                  in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  run_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BLOCK_SIDE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  lossy_block_run_length_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor copy of the registers and the open run, at reset values
  logic [SIDE_W-1:0] side_reg  = BLOCK_SIDE_RST;
  logic [DIFF_W-1:0] diff_reg  = '0;
  logic [7:0]        hold_b    = '0;
  logic [7:0]        hold_g    = '0;
  logic [7:0]        hold_r    = '0;
  logic [LEN_W-1:0]  hold_len  = '0;
  int unsigned       blk_pos   = 0;
  bit                run_live  = 1'b0;

  run_t runs_due[$];        // run words predicted but not yet seen at out_
  int   bad_runs    = 0;
  bit   in_idle_on  = 1'b1;
  bit   out_idle_on = 1'b1;
  int   stall_left  = 0;
  int   quiet       = 0;
  run_t want;

  function automatic int draw_wait(input bit on);
    return on ? int'($urandom_range(STALL_MAX, 0)) : 0;
  endfunction

  function automatic int unsigned chan_dist(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // small random step of one channel, kept inside 0..255
  function automatic logic [7:0] nudge(input logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(6, 0)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic emit_held(input logic last_of_image);
    run_t w;
    w.run_blue  = hold_b;
    w.run_green = hold_g;
    w.run_red   = hold_r;
    w.run_count = hold_len;
    w.final_run = last_of_image;
    runs_due.push_back(w);
  endtask

  task automatic open_with(input pix_t p);
    hold_b   = p.pixel_blue;
    hold_g   = p.pixel_green;
    hold_r   = p.pixel_red;
    hold_len = LEN_W'(1);
    run_live = 1'b1;
  endtask

  // advance the predicted encoder by one pixel and queue the runs it closes
  task automatic encode_pixel(input pix_t p);
    int unsigned side;
    int unsigned sad_sum;
    bit          block_end;
    side = 32'(side_reg);
    if (side < 1) side = 1;
    if (side > MAX_SIDE) side = MAX_SIDE;
    // a position left past the end by a smaller side also counts as the end
    block_end = (blk_pos >= side * side - 1);
    if (!run_live) begin
      open_with(p);
    end else if (block_end) begin
      emit_held(1'b0);
      open_with(p);
    end else begin
      sad_sum = chan_dist(hold_b, p.pixel_blue) + chan_dist(hold_g, p.pixel_green)
              + chan_dist(hold_r, p.pixel_red);
      if (sad_sum <= diff_reg) begin
        if (hold_len != LEN_MAX) hold_len = hold_len + 1'b1;
      end else begin
        emit_held(1'b0);
        open_with(p);
      end
    end
    blk_pos = block_end ? 0 : blk_pos + 1;
    if (p.end_of_image) begin
      emit_held(1'b1);
      run_live = 1'b0;
      hold_len = '0;
      blk_pos  = 0;
    end
  endtask

  // one pixel word: optional gap, then hold it until the encoder takes it
  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input logic eoi);
    int   gap;
    pix_t word;
    word.pixel_blue   = b;
    word.pixel_green  = g;
    word.pixel_red    = r;
    word.end_of_image = eoi;
    gap = draw_wait(in_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_pixel(word);
  endtask

  // wait for every predicted run, then let pixels still in flight drain
  task automatic settle;
    in_valid <= 1'b0;
    @(posedge clk);
    while (runs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BLOCK_SIDE) side_reg = val[SIDE_W-1:0];
    else diff_reg = val;
    @(posedge clk);
  endtask

  // reset values: side 8, exact match only
  task automatic test_default_settings;
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);   // one-pixel image
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hff, 8'h00, 8'hff, 1'b1);   // break and flush on one pixel
  endtask

  // one-pixel blocks: every pixel ends a block, the first one still only opens
  task automatic test_unit_blocks;
    settle;
    write_reg(CFG_BLOCK_SIDE, 10'd1);
    write_reg(CFG_MAX_DIFF, 10'd765);
    send_pixel(8'h10, 8'h20, 8'h30, 1'b0);
    send_pixel(8'h10, 8'h20, 8'h30, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    settle;
    write_reg(CFG_BLOCK_SIDE, 10'd0);        // side zero behaves as one
    send_pixel(8'h01, 8'h02, 8'h03, 1'b0);
    send_pixel(8'h04, 8'h05, 8'h06, 1'b1);
  endtask

  task automatic test_diff_threshold;
    settle;
    write_reg(CFG_BLOCK_SIDE, 10'd8);
    write_reg(CFG_MAX_DIFF, 10'd10);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h05, 8'h05, 8'h00, 1'b0);   // distance exactly at the limit
    send_pixel(8'h05, 8'h05, 8'h01, 1'b1);   // one past it
    settle;
    write_reg(CFG_MAX_DIFF, 10'd765);        // full-range distance still similar
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
  endtask

  // shrink the block mid-image so the position already lies past its end
  task automatic test_block_shrink;
    int k;
    settle;
    write_reg(CFG_BLOCK_SIDE, 10'd3);
    write_reg(CFG_MAX_DIFF, 10'd0);
    for (k = 0; k < 5; k++) send_pixel(8'h5a, 8'ha5, 8'h3c, 1'b0);
    settle;
    write_reg(CFG_BLOCK_SIDE, 10'd2);
    send_pixel(8'h5a, 8'ha5, 8'h3c, 1'b0);   // forced close although similar
    send_pixel(8'h5a, 8'ha5, 8'h3c, 1'b1);
  endtask

  // side above the maximum, every pixel similar: one long run, back to back
  task automatic test_largest_block;
    int k;
    settle;
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    write_reg(CFG_BLOCK_SIDE, {3'b101, 7'd127});
    write_reg(CFG_MAX_DIFF, 10'd1023);
    for (k = 0; k < LONG_RUN; k++) begin
      send_pixel(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                 8'($urandom_range(255, 0)), k == LONG_RUN - 1);
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // images of random length and texture under changing settings
  task automatic test_random_images;
    int          sent;
    int          len;
    int          k;
    logic [7:0]  b, g, r;
    logic [6:0]  side_val;
    logic [2:0]  junk;
    logic        eoi;
    sent = 0;
    b = 8'h80;
    g = 8'h80;
    r = 8'h80;
    while (sent < RANDOM_ITEMS) begin
      settle;
      if ($urandom_range(4, 0) != 0) begin
        case ($urandom_range(7, 0))
          0:       side_val = 7'd0;
          1:       side_val = 7'd1;
          2:       side_val = 7'd2;
          3:       side_val = 7'd64;
          4:       side_val = 7'd127;
          default: side_val = 7'($urandom_range(6, 2));
        endcase
        junk = 3'($urandom_range(7, 0));    // bits above the side register
        write_reg(CFG_BLOCK_SIDE, {junk, side_val});
      end
      if ($urandom_range(4, 0) != 0) begin
        case ($urandom_range(5, 0))
          0:       write_reg(CFG_MAX_DIFF, 10'd0);
          1:       write_reg(CFG_MAX_DIFF, 10'd765);
          2:       write_reg(CFG_MAX_DIFF, 10'd1023);
          3:       write_reg(CFG_MAX_DIFF, 10'($urandom_range(1023, 0)));
          default: write_reg(CFG_MAX_DIFF, 10'($urandom_range(24, 1)));
        endcase
      end
      in_idle_on  = ($urandom_range(3, 0) != 0);
      out_idle_on = ($urandom_range(3, 0) != 0);
      len = ($urandom_range(7, 0) == 0) ? $urandom_range(150, 40) : $urandom_range(30, 1);
      for (k = 0; k < len; k++) begin
        case ($urandom_range(9, 0))
          0, 1, 2, 3: ;                     // repeat: grows the run
          4, 5, 6: begin
            b = nudge(b);
            g = nudge(g);
            r = nudge(r);
          end
          default: begin
            b = 8'($urandom_range(255, 0));
            g = 8'($urandom_range(255, 0));
            r = 8'($urandom_range(255, 0));
          end
        endcase
        // mostly well-formed images; some run on into the next phase,
        // a few end early
        if (k == len - 1) eoi = ($urandom_range(9, 0) != 0);
        else eoi = ($urandom_range(49, 0) == 0);
        send_pixel(b, g, r, eoi);
        sent++;
      end
    end
  endtask

  // receiver: check each run word against the oldest prediction, then draw the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (runs_due.size() == 0) begin
        bad_runs++;
        if (bad_runs <= SHOWN_MAX)
          $display("unexpected run word: b=%h g=%h r=%h count=%0d last=%b",
                   out_data.run_blue, out_data.run_green, out_data.run_red,
                   out_data.run_count, out_data.final_run);
      end else begin
        want = runs_due.pop_front();
        if (out_data.run_blue !== want.run_blue || out_data.run_green !== want.run_green ||
            out_data.run_red !== want.run_red || out_data.run_count !== want.run_count ||
            out_data.final_run !== want.final_run) begin
          bad_runs++;
          if (bad_runs <= SHOWN_MAX)
            $display("run word mismatch: expected b=%h g=%h r=%h count=%0d last=%b, %s",
                     want.run_blue, want.run_green, want.run_red, want.run_count,
                     want.final_run,
                     $sformatf("got b=%h g=%h r=%h count=%0d last=%b",
                               out_data.run_blue, out_data.run_green, out_data.run_red,
                               out_data.run_count, out_data.final_run));
        end
      end
      stall_left = draw_wait(out_idle_on);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  // watchdog: any word moving on either side restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_MAX) begin
      $display("lossy_block_run_length_encoder verification failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_settings;
    test_unit_blocks;
    test_diff_threshold;
    test_block_shrink;
    test_largest_block;
    test_random_images;
    settle;
    repeat (8) @(posedge clk);
    if (bad_runs == 0 && runs_due.size() == 0)
      $display("lossy_block_run_length_encoder verification clean");
    else
      $display("lossy_block_run_length_encoder verification failed");
    $finish;
  end

endmodule
